// ----- rtl/gocc_pkg.sv -----
// Package for the occupancy grid clearance cost unit.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps
package gocc_pkg;
  localparam int CellMm = 100;
  localparam int YOriginMm = 1500;
  localparam logic signed [21:0] EMPTY_COST = 22'sd100000;
  localparam logic [0:0] CMD_WRITE = 1'b0;
  localparam logic [0:0] CMD_EVAL = 1'b1;
  localparam logic [9:0] RADIUS_RESET = 10'd150;
endpackage

// ----- rtl/gocc_isqrt.sv -----
// Iterative integer square root, one root bit per cycle.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
module gocc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [32:0] radicand,
  output logic        done,
  output logic [16:0] root
);
  logic [33:0] rem;
  logic [33:0] bitv;
  logic [33:0] res;
  logic        active;
  logic [33:0] trial;

  assign trial = res + bitv;
  assign root = res[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        rem <= {1'b0, radicand};
        res <= '0;
        bitv <= 34'h1 << 32;
      end else if (active) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/grid_obstacle_clearance_cost_unit.sv -----
// Top level: occupancy grid, APB register, and the scan sequencer.
// Depends on gocc_pkg and gocc_isqrt.
//
// Channel | Signals                                   | Direction
// command | start/busy, command, cell_*, pose_*       | in (busy: out)
// result  | done, collision, clearance_cost           | out
// config  | psel penable pwrite paddr pwdata prdata   | in/out
//
// A write item updates the grid at its accepting edge; done follows in the next cycle
// and busy stays low. An evaluate item holds busy while it scans every cell in order: a
// free cell passes S_CELL and S_ACC; an occupied cell also passes S_SQ and S_SQRT, where
// it waits on the shared square root unit. done rises from S_END once the scan ends.
// Reset clears the grid at once (row flip-flops).
// done is a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
module grid_obstacle_clearance_cost_unit
  import gocc_pkg::*;
#(
  parameter int GRID_CELLS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [4:0]         cell_row,
  input  logic [4:0]         cell_col,
  input  logic               cell_occupied,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  output logic               done,
  output logic               collision,
  output logic signed [21:0] clearance_cost,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int IW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  // ceil(2^19 / 100); exact for magnitudes below 43690
  localparam logic [12:0] RecipHundred = 13'd5243;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_HIT, S_CELL, S_SQ, S_SQRT, S_ACC, S_END
  } state_t;

  state_t state;
  logic [GRID_CELLS-1:0] grid [GRID_CELLS];
  logic [9:0] radius;
  logic signed [15:0] px, py;
  logic [IW-1:0] ci, cj;
  logic signed [17:0] dx, dy;
  logic [32:0] sq;
  logic signed [25:0] sum;
  logic sq_go, sq_done;
  logic [16:0] sq_root;
  logic [1:0] sqph;
  logic signed [35:0] prod;
  logic signed [17:0] mul_a;

  // pose cell indices
  logic signed [16:0] xs, cx_raw, cy_raw, ysh, cxq, cyq;
  logic [16:0] xa, ya;
  logic [29:0] xq_p, yq_p;
  logic [10:0] xq, yq;
  logic [IW-1:0] cyc, cx0, cxp, cxm;
  logic [4:0] wr_row, wr_col;

  function automatic logic [IW-1:0] clampi(input logic signed [16:0] v);
    if (v < 0) return '0;
    if (v > 17'(GRID_CELLS - 1)) return IW'(GRID_CELLS - 1);
    return v[IW-1:0];
  endfunction

  assign xs = 17'(px);
  assign ysh = 17'(py) + 17'(YOriginMm);
  // divide the magnitude by 100, then restore the sign (truncates toward zero)
  assign xa = xs[16] ? 17'(-xs) : 17'(xs);
  assign ya = ysh[16] ? 17'(-ysh) : 17'(ysh);
  assign xq_p = 30'(xa) * 30'(RecipHundred);
  assign yq_p = 30'(ya) * 30'(RecipHundred);
  assign xq = xq_p[29:19];
  assign yq = yq_p[29:19];
  assign cx_raw = xs[16] ? -17'(xq) : 17'(xq);
  assign cy_raw = ysh[16] ? -17'(yq) : 17'(yq);
  assign cyc = clampi(cyq);
  assign cx0 = clampi(cxq);
  assign cxp = clampi(cxq + 17'sd1);
  assign cxm = clampi(cxq - 17'sd1);

  assign mul_a = sqph[0] ? dy : dx;
  assign prod = mul_a * mul_a;
  assign wr_row = cell_row;
  assign wr_col = cell_col;

  assign busy = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {22'd0, radius} : 32'd0;

  logic signed [17:0] d;
  logic signed [17:0] r2;
  assign r2 = 18'(radius) <<< 1;
  assign d = $signed({1'b0, sq_root}) - $signed({8'd0, radius});

  gocc_isqrt u_sqrt (
    .clk(clk), .rst(rst), .go(sq_go), .radicand(sq),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      radius <= RADIUS_RESET;
      sq_go <= 1'b0;
      for (int k = 0; k < GRID_CELLS; k++) grid[k] <= '0;
    end else begin
      done <= 1'b0;
      sq_go <= 1'b0;
      if (psel && penable && pwrite && paddr == 2'd0) radius <= pwdata[9:0];
      case (state)
        S_IDLE: begin
          if (start) begin
            if (command == CMD_WRITE) begin
              if (32'(wr_row) < GRID_CELLS && 32'(wr_col) < GRID_CELLS)
                grid[IW'(wr_row)][IW'(wr_col)] <= cell_occupied;
              collision <= 1'b0;
              clearance_cost <= '0;
              done <= 1'b1;
            end else begin
              px <= pose_x;
              py <= pose_y;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          cxq <= cx_raw;
          cyq <= cy_raw;
          state <= S_HIT;
        end
        S_HIT: begin
          collision <= grid[cx0][cyc] | grid[cxp][cyc] | grid[cxm][cyc];
          ci <= '0;
          cj <= '0;
          sum <= '0;
          state <= S_CELL;
        end
        S_CELL: begin
          if (grid[ci][cj]) begin
            dx <= 18'(px) - 18'((32'(ci) + 1) * CellMm);
            dy <= 18'(py) - 18'((32'(cj) + 1) * CellMm - YOriginMm);
            sqph <= 2'd0;
            state <= S_SQ;
          end else begin
            state <= S_ACC;
          end
        end
        S_SQ: begin
          // square dx then dy through one multiplier
          if (sqph == 2'd0) begin
            sq <= 33'(prod);
            sqph <= 2'd1;
          end else begin
            sq <= sq + 33'(prod);
            sq_go <= 1'b1;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            sum <= sum + 26'((d >= r2) ? r2 : d);
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (cj == IW'(GRID_CELLS - 1)) begin
            cj <= '0;
            if (ci == IW'(GRID_CELLS - 1)) state <= S_END;
            else ci <= ci + 1'b1;
          end else begin
            cj <= cj + 1'b1;
          end
          if (!(cj == IW'(GRID_CELLS - 1) && ci == IW'(GRID_CELLS - 1))) state <= S_CELL;
        end
        S_END: begin
          if (sum == 0) clearance_cost <= EMPTY_COST;
          else if (sum > 26'sd2097151) clearance_cost <= 22'sh1FFFFF;
          else if (sum < -26'sd2097152) clearance_cost <= 22'sh200000;
          else clearance_cost <= sum[21:0];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- tb/grid_obstacle_clearance_cost_unit_tb.sv -----
// Testbench for grid_obstacle_clearance_cost_unit: random and directed grid writes and
// pose evaluations, checked against an in-bench occupancy grid and cost predictor.
// Depends on gocc_pkg and the unit RTL.
`timescale 1ns / 1ps
module grid_obstacle_clearance_cost_unit_tb
  import gocc_pkg::*;
();

  localparam int Cells = 32;
  localparam int WatchLimit = 100000;
  localparam logic [1:0] ADDR_RADIUS = 2'd0;

  typedef struct {
    logic [0:0]         cmd;
    logic [4:0]         row;
    logic [4:0]         col;
    logic               occ;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } grid_item_t;

  typedef struct {
    logic               hit;
    logic signed [21:0] cost;
  } pose_result_t;

  logic clk, rst, start, busy, command, cell_occupied, done, collision;
  logic [4:0] cell_row, cell_col;
  logic signed [15:0] pose_x, pose_y;
  logic signed [21:0] clearance_cost;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  grid_obstacle_clearance_cost_unit #(.GRID_CELLS(Cells)) uut (.*);

  grid_item_t pending_items[$];
  pose_result_t expected_results[$];
  bit [31:0] grid_rows[Cells];
  int unsigned radius_mm;
  int fail_count = 0;
  int idle_cycles = 0;
  bit took_item = 0;
  int gap_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic int clamp_cell(int v);
    if (v < 0) return 0;
    if (v > Cells - 1) return Cells - 1;
    return v;
  endfunction

  // Update the grid for writes, compute collision and clearance cost for poses.
  function automatic pose_result_t apply_grid_item(grid_item_t it);
    pose_result_t r;
    int x, y, cx, cy;
    longint dx, dy, d, total, r1, r2;
    r.hit = 0;
    r.cost = '0;
    if (it.cmd == CMD_WRITE) begin
      grid_rows[it.row][it.col] = it.occ;
      return r;
    end
    x = it.px;
    y = it.py;
    cx = x / CellMm;
    cy = clamp_cell((y + YOriginMm) / CellMm);
    r.hit = grid_rows[clamp_cell(cx)][cy] | grid_rows[clamp_cell(cx + 1)][cy] |
            grid_rows[clamp_cell(cx - 1)][cy];
    r1 = radius_mm;
    r2 = 2 * r1;
    total = 0;
    for (int i = 0; i < Cells; i++) begin
      for (int j = 0; j < Cells; j++) begin
        if (grid_rows[i][j]) begin
          dx = x - (i + 1) * CellMm;
          dy = y - ((j + 1) * CellMm - YOriginMm);
          d = longint'(int_sqrt(dx * dx + dy * dy)) - r1;
          if (d >= r2) d = r2;
          total += d;
        end
      end
    end
    if (total == 0) total = 100000;
    if (total > 2097151) total = 2097151;
    if (total < -2097152) total = -2097152;
    r.cost = total[21:0];
    return r;
  endfunction

  // Accept items and results at the rising edge.
  always @(posedge clk) begin
    pose_result_t want;
    took_item <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result collision=%0b cost=%0d", $time, collision,
                   clearance_cost);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (collision !== want.hit) begin
            $display("%0t: collision expected %0b actual %0b", $time, want.hit, collision);
            fail_count++;
          end
          if (clearance_cost !== want.cost) begin
            $display("%0t: clearance_cost expected %0d actual %0d", $time, want.cost,
                     clearance_cost);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.insert(expected_results.size(),
                                apply_grid_item('{command, cell_row, cell_col,
                                                  cell_occupied, pose_x, pose_y}));
      end
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Driver: present the next item after a random gap; fields change at the falling edge.
  always @(negedge clk) begin
    grid_item_t it;
    bit load;
    load = 0;
    if (rst) begin
      start <= 0;
    end else if (start && !took_item) begin
      // hold until accepted
    end else begin
      if (start) gap_left = $urandom_range(0, 13);
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() != 0) begin
        load = 1;
      end
      if (load) begin
        it = pending_items.pop_front();
        command <= it.cmd;
        cell_row <= it.row;
        cell_col <= it.col;
        cell_occupied <= it.occ;
        pose_x <= it.px;
        pose_y <= it.py;
      end
      start <= load;
    end
  end

  task automatic write_radius(input int unsigned v);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= ADDR_RADIUS;
    pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    radius_mm = v & 32'h3FF;
  endtask

  // Wait for the driver to empty and for every result to come back.
  task automatic drain();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic add_write(int r, int c, bit o);
    pending_items.insert(pending_items.size(),
                         '{CMD_WRITE, 5'(r), 5'(c), o, 16'($urandom), 16'($urandom)});
  endtask

  task automatic add_pose(int x, int y);
    pending_items.insert(pending_items.size(),
                         '{CMD_EVAL, 5'($urandom), 5'($urandom), 1'($urandom),
                           16'(x), 16'(y)});
  endtask

  task automatic add_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 6) begin
        add_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
      end else if ($urandom_range(0, 3) == 0) begin
        add_pose($signed(16'($urandom)), $signed(16'($urandom)));
      end else begin
        add_pose($urandom_range(0, 3400) - 100, $urandom_range(0, 3400) - 1600);
      end
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    command = 0;
    cell_row = 0;
    cell_col = 0;
    cell_occupied = 0;
    pose_x = 0;
    pose_y = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    radius_mm = RADIUS_RESET;
    foreach (grid_rows[i]) grid_rows[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty grid, corners, collision neighbors, pose extremes.
    add_pose(0, 0);
    add_write(0, 0, 1);
    add_write(31, 31, 1);
    add_write(31, 0, 1);
    add_write(5, 15, 1);
    add_pose(32767, 32767);
    add_pose(-32768, -32768);
    add_pose(-32768, 32767);
    add_pose(550, 0);
    add_pose(450, 0);
    add_pose(650, 0);
    add_pose(750, 50);
    add_pose(-99, -1599);
    add_pose(3199, 1699);
    add_write(5, 15, 0);
    add_pose(550, 0);
    add_write(10, 10, 1);
    add_pose(1100, -400);
    add_write(0, 0, 0);
    add_write(31, 31, 0);
    add_write(31, 0, 0);
    add_write(10, 10, 0);
    add_pose(1000, 0);
    drain();

    write_radius(0);
    add_write(3, 3, 1);
    add_pose(400, -1100);
    add_random(70);
    drain();

    write_radius(1000);
    add_random(70);
    drain();

    write_radius(1023);
    add_random(60);
    drain();

    write_radius($urandom_range(1, 400));
    add_random(70);
    drain();

    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/gocc_pkg.sv
rtl/gocc_isqrt.sv
rtl/grid_obstacle_clearance_cost_unit.sv
tb/grid_obstacle_clearance_cost_unit_tb.sv
